/* src/ftlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table package
// Shared status codes, command codes and hash constants.
// ----------------------------------------------------------------------------
package ftlp_pkg;

   localparam logic [31:0] HASH_BASIS = 32'd2166136261;
   localparam logic [31:0] HASH_PRIME = 32'd16777619;
   localparam int          KEY_BYTES  = 13;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

endpackage

/* src/ftlp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ftlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* src/flow_table_linear_probe_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table with linear probing
// Five-tuple keyed put/get table using FNV-1a hashing.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request hashes the key one byte per
// cycle through a single 32x32 multiplier, then reads and checks the probed
// slots one at a time (S_READ, then S_CHECK) through the one read port of
// the slot memory, and S_DONE presents the response. A put to a full table
// skips hashing and is answered in the cycle after it is taken. After reset,
// and after every capacity write, a clearing pass writes every slot of the
// slot memory to zero before requests are taken.
module flow_table_linear_probe_top
   import ftlp_pkg::*;
#(
   parameter int TABLE_DEPTH  = 1024,
   parameter int ACTION_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_src_ip,
   input  logic [31:0] req_dst_ip,
   input  logic [15:0] req_sport,
   input  logic [15:0] req_dport,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_action_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_action_out,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int CW  = AW + 1;
   localparam int KW  = 104;
   localparam int RW  = 1 + KW + ACTION_WIDTH;
   localparam int MAXLG = AW;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_HASH  = 6'b000100,
      S_READ  = 6'b001000,
      S_CHECK = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         lg_ff, lg_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [3:0]         byte_ff, byte_in;
   logic [31:0]        hash_ff, hash_in;
   logic               cmd_ff, cmd_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [ACTION_WIDTH-1:0] act_ff, act_in;
   logic               rv_ff, rv_in;
   logic [1:0]         st_ff, st_in;
   logic [31:0]        ao_ff, ao_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [RW-1:0]      wr_data, rd_data;
   logic [CW-1:0]      cap;
   logic [AW-1:0]      mask;
   logic [3:0]         lg_eff;
   logic [7:0]         cur_byte;
   logic [31:0]        mixed;
   logic [63:0]        prod;
   logic               slot_v;
   logic               slot_hit;
   logic [31:0]        act_ext;

   ftlp_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(idx_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      lg_eff = (lg_ff == 4'd0) ? 4'd1 : lg_ff;
      if (32'(lg_eff) > MAXLG) begin
         lg_eff = 4'(MAXLG);
      end
      cap  = CW'(1) << lg_eff;
      mask = AW'(cap - CW'(1));
   end

   assign cur_byte = key_ff[8*byte_ff +: 8];
   assign mixed    = hash_ff ^ {24'd0, cur_byte};
   assign prod     = mixed * HASH_PRIME;
   assign slot_v   = rd_data[RW-1];
   assign slot_hit = rd_data[RW-2 -: KW] == key_ff;
   assign act_ext  = 32'(rd_data[ACTION_WIDTH-1:0]);

   assign req_ready      = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid      = rv_ff;
   assign rsp_status     = st_ff;
   assign rsp_action_out = ao_ff;

   always_comb begin
      state_in = state_ff;
      lg_in    = lg_ff;
      cnt_in   = cnt_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      hash_in  = hash_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      act_in   = act_ff;
      rv_in    = rv_ff;
      st_in    = st_ff;
      ao_in    = ao_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = {1'b1, key_ff, act_ff};
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            idx_in  = idx_ff + AW'(1);
            if (idx_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in  = req_command;
               key_in  = {req_protocol, req_dport, req_sport,
                          req_dst_ip, req_src_ip};
               act_in  = ACTION_WIDTH'(req_action_in);
               hash_in = HASH_BASIS;
               byte_in = '0;
               if (req_command == CMD_PUT && count_ff >= cap) begin
                  rv_in    = 1'b1;
                  st_in    = ST_FULL;
                  ao_in    = '0;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            hash_in = prod[31:0];
            byte_in = byte_ff + 4'd1;
            if (byte_ff == 4'(KEY_BYTES - 1)) begin
               state_in = S_READ;
               idx_in   = prod[AW-1:0] & mask;
               cnt_in   = '0;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_DONE;
            ao_in    = '0;
            if (!slot_v) begin
               if (cmd_ff == CMD_PUT) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  st_in    = ST_OK;
               end else begin
                  st_in = ST_MISS;
               end
            end else if (slot_hit) begin
               st_in = ST_OK;
               if (cmd_ff == CMD_PUT) begin
                  wr_en = 1'b1;
               end else begin
                  ao_in = act_ext;
               end
            end else if (cnt_ff + CW'(1) >= cap) begin
               st_in = (cmd_ff == CMD_PUT) ? ST_FULL : ST_MISS;
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               idx_in   = (idx_ff + AW'(1)) & mask;
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rv_ff) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_write_enable) begin
         lg_in    = csr_write_data;
         count_in = '0;
         idx_in   = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         lg_ff    <= 4'd10;
         count_ff <= '0;
         idx_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         lg_ff    <= lg_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         rv_ff    <= rv_in;
      end
      cnt_ff  <= cnt_in;
      byte_ff <= byte_in;
      hash_ff <= hash_in;
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      act_ff  <= act_in;
      st_ff   <= st_in;
      ao_ff   <= ao_in;
   end

endmodule

/* src/ftlp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow table checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module ftlp_checker
   import ftlp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_action_out
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("request withdrawn before it was taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("illegal status code");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_action_out == 32'd0)
      else $error("action on failed request");

   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

endmodule

bind flow_table_linear_probe_top ftlp_checker u_ftlp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_action_out(rsp_action_out)
);
